>>> src/flex_pkg.sv
// ----------------------------------------------------------------------------
// flex_pkg: shared types and constants of the formula lexer
// Payload structs, token kinds, error codes, scan modes and the punctuation
// lookup.
// ----------------------------------------------------------------------------
package flex_pkg;

  localparam int unsigned MaxLen = 65535;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharDquote = 8'h22;

  localparam logic [4:0] KindEscape = 5'd18;
  localparam logic [4:0] KindNumber = 5'd19;
  localparam logic [4:0] KindWord   = 5'd20;
  localparam logic [4:0] KindQuoted = 5'd21;

  typedef enum logic [2:0] {
    ErrNone              = 3'd0,
    ErrBadChar           = 3'd1,
    ErrUnclosedQuote     = 3'd2,
    ErrTrailingBackslash = 3'd3,
    ErrTooLong           = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeNumber = 3'd1,
    ModeWord   = 3'd2,
    ModeQuote  = 3'd3,
    ModeEscape = 3'd4,
    ModeError  = 3'd5
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  escaped_char;
    logic [2:0]  error_code;
    logic        string_done;
    logic        has_token;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_t;

  // punctuation kinds follow the order = . , ( ) + - * / ^ $ % ' < > ? : _
  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t p;
    p.hit  = 1'b1;
    p.kind = 5'd0;
    case (c)
      8'h3D: p.kind = 5'd0;
      8'h2E: p.kind = 5'd1;
      8'h2C: p.kind = 5'd2;
      8'h28: p.kind = 5'd3;
      8'h29: p.kind = 5'd4;
      8'h2B: p.kind = 5'd5;
      8'h2D: p.kind = 5'd6;
      8'h2A: p.kind = 5'd7;
      8'h2F: p.kind = 5'd8;
      8'h5E: p.kind = 5'd9;
      8'h24: p.kind = 5'd10;
      8'h25: p.kind = 5'd11;
      8'h27: p.kind = 5'd12;
      8'h3C: p.kind = 5'd13;
      8'h3E: p.kind = 5'd14;
      8'h3F: p.kind = 5'd15;
      8'h3A: p.kind = 5'd16;
      8'h5F: p.kind = 5'd17;
      default: p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic out_t mk_res(input logic [4:0] kind, input logic [15:0] start,
                                  input logic [15:0] len, input logic [7:0] esc,
                                  input err_e err, input logic has);
    out_t r;
    r.token_kind   = kind;
    r.token_start  = start;
    r.token_length = len;
    r.escaped_char = esc;
    r.error_code   = err;
    r.string_done  = 1'b0;
    r.has_token    = has;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

>>> src/formula_lexer.sv
// ----------------------------------------------------------------------------
// formula_lexer: streaming tokenizer for formula strings
// One character per transaction in; up to two token or status results out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  input   | in        | in_valid_i / in_ready_o   | flex_pkg::in_t  in_data_i
//  output  | out       | out_valid_o / out_ready_i | flex_pkg::out_t out_data_o
//
//  A character is decoded in the cycle it is accepted and its results land in
//  a four-entry output queue; the first result is visible the next cycle if the
//  queue was empty. One character per cycle is accepted while the queue holds
//  two or fewer results, so the output side (one per unstalled cycle) sets the
//  sustained rate. Reset returns the scanner to idle at offset zero and empties
//  the queue. Output stalls back up through the queue to in_ready_o.
// ----------------------------------------------------------------------------
module formula_lexer #(
  parameter int unsigned MAX_LEN = flex_pkg::MaxLen
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  flex_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output flex_pkg::out_t  out_data_o
);

  localparam int unsigned PosW   = $clog2(MAX_LEN + 1);
  localparam int unsigned QDepth = 4;

  flex_pkg::scan_mode_e mode_q, mode_d, mode_s;
  logic [PosW-1:0]      pos_q, pos_d, pos_s;
  logic [PosW-1:0]      rs_q, rs_d, rs_s;

  flex_pkg::out_t       queue_q [QDepth];
  flex_pkg::out_t       queue_d [QDepth];
  logic [2:0]           cnt_q, cnt_d;

  logic       accept, pop;
  logic [7:0] c;
  logic       eos;
  logic       is_space, is_digit, is_letter, is_bslash, is_dquote;
  flex_pkg::punct_t punct;
  logic       active, too_long, handled, run_end, quote_close, bad_char;

  logic [PosW+15:0] pos_w, rs_w, rs_s_w, len_w, len_s_w;
  logic [PosW-1:0]  len_q, len_s;

  flex_pkg::out_t c1, c2, c3, r0, r1;
  logic           c1_v, c2_v, c3_v;
  logic [1:0]     n_res, n_push;
  logic [2:0]     base;

  assign accept = in_valid_i & in_ready_o;
  assign pop    = out_valid_o & out_ready_i;
  assign c      = in_data_i.char_byte;
  assign eos    = in_data_i.end_of_string;

  // character classes
  assign is_space  = (c == flex_pkg::CharSpace);
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign is_bslash = (c == flex_pkg::CharBslash);
  assign is_dquote = (c == flex_pkg::CharDquote);
  assign punct     = flex_pkg::punct_lookup(c);

  assign active   = (mode_q != flex_pkg::ModeError);
  assign too_long = (pos_q >= PosW'(MAX_LEN));
  assign handled  = (mode_q == flex_pkg::ModeEscape) || (mode_q == flex_pkg::ModeQuote) ||
                    ((mode_q == flex_pkg::ModeNumber) && is_digit) ||
                    ((mode_q == flex_pkg::ModeWord) && is_letter);
  assign run_end  = ((mode_q == flex_pkg::ModeNumber) && !is_digit) ||
                    ((mode_q == flex_pkg::ModeWord) && !is_letter);
  assign quote_close = (mode_q == flex_pkg::ModeQuote) && is_dquote;
  assign bad_char = !handled && !is_space && !punct.hit && !is_bslash && !is_digit &&
                    !is_letter && !is_dquote;

  // offsets are reported modulo 2^16
  assign len_q   = pos_q - rs_q;
  assign len_s   = pos_s - rs_s;
  assign pos_w   = {16'd0, pos_q};
  assign rs_w    = {16'd0, rs_q};
  assign rs_s_w  = {16'd0, rs_s};
  assign len_w   = {16'd0, len_q};
  assign len_s_w = {16'd0, len_s};

  // next state
  always_comb begin
    mode_s = mode_q;
    pos_s  = pos_q;
    rs_s   = rs_q;
    if (active) begin
      if (too_long) begin
        mode_s = flex_pkg::ModeError;
      end else begin
        case (mode_q)
          flex_pkg::ModeEscape: mode_s = flex_pkg::ModeIdle;
          flex_pkg::ModeQuote:  if (is_dquote) mode_s = flex_pkg::ModeIdle;
          flex_pkg::ModeNumber: if (!is_digit) mode_s = flex_pkg::ModeIdle;
          flex_pkg::ModeWord:   if (!is_letter) mode_s = flex_pkg::ModeIdle;
          default:              mode_s = flex_pkg::ModeIdle;
        endcase
        if (!handled) begin
          if (is_bslash) begin
            mode_s = flex_pkg::ModeEscape;
          end else if (is_digit) begin
            mode_s = flex_pkg::ModeNumber;
            rs_s   = pos_q;
          end else if (is_letter) begin
            mode_s = flex_pkg::ModeWord;
            rs_s   = pos_q;
          end else if (is_dquote) begin
            mode_s = flex_pkg::ModeQuote;
            rs_s   = pos_q + 1'b1;
          end else if (bad_char) begin
            mode_s = flex_pkg::ModeError;
          end
        end
        if (mode_s != flex_pkg::ModeError) pos_s = pos_q + 1'b1;
      end
    end
    if (eos) begin
      mode_d = flex_pkg::ModeIdle;
      pos_d  = '0;
      rs_d   = '0;
    end else begin
      mode_d = mode_s;
      pos_d  = pos_s;
      rs_d   = rs_s;
    end
  end

  // result candidates, in emission order
  always_comb begin
    c1   = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0, flex_pkg::ErrNone, 1'b0);
    c2   = c1;
    c3   = c1;
    c1_v = 1'b0;
    c2_v = 1'b0;
    c3_v = 1'b0;
    if (active) begin
      if (too_long) begin
        c1_v = 1'b1;
        c1   = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0, flex_pkg::ErrTooLong, 1'b0);
      end else begin
        if (mode_q == flex_pkg::ModeEscape) begin
          c1_v = 1'b1;
          c1   = flex_pkg::mk_res(flex_pkg::KindEscape, pos_w[15:0], 16'd1, c,
                                  flex_pkg::ErrNone, 1'b1);
        end else if (quote_close) begin
          c1_v = 1'b1;
          c1   = flex_pkg::mk_res(flex_pkg::KindQuoted, rs_w[15:0], len_w[15:0], 8'd0,
                                  flex_pkg::ErrNone, 1'b1);
        end else if (run_end) begin
          c1_v = 1'b1;
          c1   = flex_pkg::mk_res((mode_q == flex_pkg::ModeNumber) ? flex_pkg::KindNumber
                                  : flex_pkg::KindWord, rs_w[15:0], len_w[15:0], 8'd0,
                                  flex_pkg::ErrNone, 1'b1);
        end
        if (!handled && !is_space && punct.hit) begin
          c2_v = 1'b1;
          c2   = flex_pkg::mk_res(punct.kind, pos_w[15:0], 16'd1, 8'd0,
                                  flex_pkg::ErrNone, 1'b1);
        end else if (bad_char) begin
          c2_v = 1'b1;
          c2   = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0, flex_pkg::ErrBadChar, 1'b0);
        end
      end
    end
    if (eos) begin
      case (mode_s)
        flex_pkg::ModeNumber, flex_pkg::ModeWord: begin
          c3_v = 1'b1;
          c3   = flex_pkg::mk_res((mode_s == flex_pkg::ModeNumber) ? flex_pkg::KindNumber
                                  : flex_pkg::KindWord, rs_s_w[15:0], len_s_w[15:0], 8'd0,
                                  flex_pkg::ErrNone, 1'b1);
        end
        flex_pkg::ModeQuote: begin
          c3_v = 1'b1;
          c3   = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0, flex_pkg::ErrUnclosedQuote, 1'b0);
        end
        flex_pkg::ModeEscape: begin
          c3_v = 1'b1;
          c3   = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0,
                                  flex_pkg::ErrTrailingBackslash, 1'b0);
        end
        default: c3_v = 1'b0;
      endcase
    end
  end

  // pack the first two valid candidates; a bare end fills an empty final step
  always_comb begin
    r0    = c3;
    r1    = c3;
    n_res = 2'd0;
    if (c1_v) begin
      r0 = c1;
      r1 = c2_v ? c2 : c3;
      n_res = 2'd1 + {1'b0, (c2_v | c3_v)};
    end else if (c2_v) begin
      r0 = c2;
      r1 = c3;
      n_res = 2'd1 + {1'b0, c3_v};
    end else if (c3_v) begin
      r0 = c3;
      n_res = 2'd1;
    end else if (eos) begin
      r0 = flex_pkg::mk_res(5'd0, 16'd0, 16'd0, 8'd0, flex_pkg::ErrNone, 1'b0);
      n_res = 2'd1;
    end
    if (n_res == 2'd1) begin
      r0.string_done = eos;
      r0.last_of_run = 1'b1;
    end else if (n_res == 2'd2) begin
      r1.string_done = eos;
      r1.last_of_run = 1'b1;
    end
  end

  // output queue: read at the head, shifts on pop
  assign n_push = accept ? n_res : 2'd0;
  assign base   = cnt_q - {2'b00, pop};

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) queue_d[i] = queue_q[i + 1];
      else                         queue_d[i] = queue_q[i];
      if ((n_push != 2'd0) && (3'(i) == base))        queue_d[i] = r0;
      if ((n_push == 2'd2) && (3'(i) == base + 3'd1)) queue_d[i] = r1;
    end
    cnt_d = base + {1'b0, n_push};
  end

  assign in_ready_o  = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = queue_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= flex_pkg::ModeIdle;
      pos_q  <= '0;
      rs_q   <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        rs_q   <= rs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("output queue overflow");

  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eos) |=> (mode_q == flex_pkg::ModeIdle) && (pos_q == '0) && (rs_q == '0))
    else $error("scanner state not cleared at end of string");

  a_error_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !eos && (mode_q == flex_pkg::ModeError)) |=> $stable(pos_q))
    else $error("offset advanced while ignoring bytes after an error");

  a_result_meaningful: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.has_token || (out_data_o.error_code != flex_pkg::ErrNone) ||
                     out_data_o.string_done))
    else $error("empty result in output queue");
`endif

endmodule
